### design/circuit_input_wire_finder_defines.svh
// assertion macros for the circuit input wire finder
`ifndef CIRCUIT_INPUT_WIRE_FINDER_DEFINES_SVH
`define CIRCUIT_INPUT_WIRE_FINDER_DEFINES_SVH

// condition holds at every edge out of reset
`define CWF_ASSERT_NOW(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// consequence holds in the same cycle as the antecedent
`define CWF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// consequence holds in the cycle after the antecedent
`define CWF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### design/cwf_pkg.sv
// shared types and constants for the circuit input wire finder
`timescale 1ns / 1ps

package cwf_pkg;

    localparam int WIRE_BITS_DEF       = 16;
    localparam int GATE_INDEX_BITS_DEF = 20;
    localparam int WIRE_FIELD_BITS     = 16;
    localparam int GATE_FIELD_BITS     = 20;

    localparam logic [1:0] KIND_AND = 2'd0;
    localparam logic [1:0] KIND_XOR = 2'd1;

    typedef struct packed {
        logic        start_of_circuit;
        logic [1:0]  gate_kind;
        logic [15:0] first_operand;
        logic [15:0] second_operand;
        logic [15:0] destination_wire;
    } gate_word_t;

    typedef struct packed {
        logic [15:0] input_wire;
        logic [19:0] reader_gate;
        logic        last_of_gate;
    } rpt_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DEST
    } state_t;

endpackage

### design/circuit_input_wire_finder.sv
// top level of the circuit input wire finder
`timescale 1ns / 1ps

// Circuit input wire finder. Each gate word names a gate kind, two operand
// wires and a destination wire. AND and XOR gates report each operand wire
// that no earlier gate has written and that was not reported before, first
// operand first, tagged with the running gate index; the last report of a
// gate carries last_of_gate. Other gate kinds only advance the index, which
// wraps. The written and reported bitmaps are folded into one "seen" bit per
// wire, held in a dual-port synchronous memory. A gate of another kind
// needs no memory access; an AND or XOR gate reads both operand bits,
// then marks both operands, then marks the destination, and it waits for
// room in the two-word report queue before marking its operands. After
// reset, and before any gate that carries start_of_circuit is processed,
// the memory is cleared by a sweep over all 2^WIRE_BITS entries, two
// entries per cycle, during which gate words are stalled.

`include "circuit_input_wire_finder_defines.svh"

module circuit_input_wire_finder #(
    parameter int WIRE_BITS       = cwf_pkg::WIRE_BITS_DEF,
    parameter int GATE_INDEX_BITS = cwf_pkg::GATE_INDEX_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gate_valid,
    output logic               gate_stall,
    input  cwf_pkg::gate_word_t gate_word,
    output logic               rpt_valid,
    input  logic               rpt_stall,
    output cwf_pkg::rpt_word_t rpt_word
);

    localparam int WF = cwf_pkg::WIRE_FIELD_BITS;
    localparam int GF = cwf_pkg::GATE_FIELD_BITS;

    // control state
    cwf_pkg::state_t state_reg, state_next;
    logic [WIRE_BITS-2:0]       sweep_reg, sweep_next;
    logic                       pend_reg, pend_next;
    logic [GATE_INDEX_BITS-1:0] gate_cnt_reg, gate_cnt_next;

    // latched gate word
    logic [1:0]           kind_reg;
    logic [WIRE_BITS-1:0] op1_reg;
    logic [WIRE_BITS-1:0] op2_reg;
    logic [WIRE_BITS-1:0] dest_reg;

    // report queue, two words deep
    cwf_pkg::rpt_word_t slot_reg [2];
    logic       rq_wr_reg, rq_rd_reg;
    logic [1:0] rq_count_reg, rq_count_next;

    // memory ports
    logic                 a_en, a_we, a_wdata, a_rdata;
    logic                 b_en, b_we, b_wdata, b_rdata;
    logic [WIRE_BITS-1:0] a_addr, b_addr;

    logic               gate_acc;
    logic               in_logic;
    logic               kind_logic;
    logic               sweep_done;
    logic               fresh1, fresh2;
    logic [1:0]         rpt_n;
    logic [1:0]         push_n;
    logic               room;
    logic               pop;
    cwf_pkg::rpt_word_t rep1, rep2, first_rep;

    assign gate_stall = (state_reg != cwf_pkg::ST_IDLE);
    assign gate_acc   = gate_valid && !gate_stall;
    assign in_logic   = (gate_word.gate_kind == cwf_pkg::KIND_AND) ||
                        (gate_word.gate_kind == cwf_pkg::KIND_XOR);
    assign kind_logic = (kind_reg == cwf_pkg::KIND_AND) ||
                        (kind_reg == cwf_pkg::KIND_XOR);
    assign sweep_done = &sweep_reg;

    // an operand is fresh when its seen bit is clear; a repeated operand once
    assign fresh1 = !a_rdata;
    assign fresh2 = !b_rdata && (op2_reg != op1_reg);
    assign rpt_n  = {1'b0, fresh1} + {1'b0, fresh2};
    assign room   = ({1'b0, rq_count_reg} + {1'b0, rpt_n}) <= 3'd2;
    assign push_n = (state_reg == cwf_pkg::ST_CHECK && room) ? rpt_n : 2'd0;

    assign rpt_valid = (rq_count_reg != 2'd0);
    assign rpt_word  = slot_reg[rq_rd_reg];
    assign pop       = rpt_valid && !rpt_stall;

    always_comb
    begin
        rep1.input_wire   = WF'(op1_reg);
        rep1.reader_gate  = GF'(gate_cnt_reg);
        rep1.last_of_gate = !fresh2;
        rep2.input_wire   = WF'(op2_reg);
        rep2.reader_gate  = GF'(gate_cnt_reg);
        rep2.last_of_gate = 1'b1;
        first_rep         = fresh1 ? rep1 : rep2;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cwf_pkg::ST_CLEAR:
            begin
                if (sweep_done)
                begin
                    state_next = (pend_reg && kind_logic) ? cwf_pkg::ST_READ
                                                          : cwf_pkg::ST_IDLE;
                end
            end
            cwf_pkg::ST_IDLE:
            begin
                if (gate_acc)
                begin
                    priority if (gate_word.start_of_circuit)
                    begin
                        state_next = cwf_pkg::ST_CLEAR;
                    end
                    else if (in_logic)
                    begin
                        state_next = cwf_pkg::ST_CHECK;
                    end
                    else
                    begin
                        state_next = cwf_pkg::ST_IDLE;
                    end
                end
            end
            cwf_pkg::ST_READ:
            begin
                state_next = cwf_pkg::ST_CHECK;
            end
            cwf_pkg::ST_CHECK:
            begin
                if (room)
                begin
                    state_next = cwf_pkg::ST_DEST;
                end
            end
            cwf_pkg::ST_DEST:
            begin
                state_next = cwf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cwf_pkg::ST_IDLE;
            end
        endcase
    end

    // memory control, counters
    always_comb
    begin
        a_en          = 1'b0;
        a_we          = 1'b0;
        a_wdata       = 1'b1;
        a_addr        = op1_reg;
        b_en          = 1'b0;
        b_we          = 1'b0;
        b_wdata       = 1'b1;
        b_addr        = op2_reg;
        sweep_next    = sweep_reg;
        pend_next     = pend_reg;
        gate_cnt_next = gate_cnt_reg;
        unique case (state_reg)
            cwf_pkg::ST_CLEAR:
            begin
                // two entries cleared per cycle
                a_en       = 1'b1;
                a_we       = 1'b1;
                a_wdata    = 1'b0;
                a_addr     = {sweep_reg, 1'b0};
                b_en       = 1'b1;
                b_we       = 1'b1;
                b_wdata    = 1'b0;
                b_addr     = {sweep_reg, 1'b1};
                sweep_next = sweep_reg + 1'b1;
                if (sweep_done)
                begin
                    pend_next     = 1'b0;
                    gate_cnt_next = (pend_reg && !kind_logic)
                                  ? GATE_INDEX_BITS'(1) : '0;
                end
            end
            cwf_pkg::ST_IDLE:
            begin
                if (gate_acc)
                begin
                    priority if (gate_word.start_of_circuit)
                    begin
                        pend_next  = 1'b1;
                        sweep_next = '0;
                    end
                    else if (in_logic)
                    begin
                        a_en   = 1'b1;
                        a_addr = WIRE_BITS'(gate_word.first_operand);
                        b_en   = 1'b1;
                        b_addr = WIRE_BITS'(gate_word.second_operand);
                    end
                    else
                    begin
                        gate_cnt_next = gate_cnt_reg + 1'b1;
                    end
                end
            end
            cwf_pkg::ST_READ:
            begin
                a_en = 1'b1;
                b_en = 1'b1;
            end
            cwf_pkg::ST_CHECK:
            begin
                // marking an operand seen is harmless whether fresh or not;
                // a repeated operand is marked through port a only
                if (room)
                begin
                    a_en = 1'b1;
                    a_we = 1'b1;
                    b_en = (op2_reg != op1_reg);
                    b_we = (op2_reg != op1_reg);
                end
            end
            cwf_pkg::ST_DEST:
            begin
                a_en          = 1'b1;
                a_we          = 1'b1;
                a_addr        = dest_reg;
                gate_cnt_next = gate_cnt_reg + 1'b1;
            end
            default:
            begin
                a_en = 1'b0;
            end
        endcase
    end

    assign rq_count_next = rq_count_reg + push_n - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cwf_pkg::ST_CLEAR;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
            gate_cnt_reg <= '0;
            rq_wr_reg    <= 1'b0;
            rq_rd_reg    <= 1'b0;
            rq_count_reg <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            pend_reg     <= pend_next;
            gate_cnt_reg <= gate_cnt_next;
            rq_count_reg <= rq_count_next;
            rq_wr_reg    <= rq_wr_reg ^ push_n[0];
            rq_rd_reg    <= rq_rd_reg ^ pop;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (gate_acc)
        begin
            kind_reg <= gate_word.gate_kind;
            op1_reg  <= WIRE_BITS'(gate_word.first_operand);
            op2_reg  <= WIRE_BITS'(gate_word.second_operand);
            dest_reg <= WIRE_BITS'(gate_word.destination_wire);
        end
        if (push_n != 2'd0)
        begin
            slot_reg[rq_wr_reg] <= first_rep;
        end
        if (push_n == 2'd2)
        begin
            slot_reg[~rq_wr_reg] <= rep2;
        end
    end

    cwf_seen_mem #(
        .ADDR_BITS (WIRE_BITS)
    ) u_seen (
        .clk     (clk),
        .a_en    (a_en),
        .a_we    (a_we),
        .a_addr  (a_addr),
        .a_wdata (a_wdata),
        .a_rdata (a_rdata),
        .b_en    (b_en),
        .b_we    (b_we),
        .b_addr  (b_addr),
        .b_wdata (b_wdata),
        .b_rdata (b_rdata)
    );

    // the report queue never holds more than two words
    `CWF_ASSERT_NOW(a_queue_bound, rq_count_reg != 2'd3)
    // destination marking closes the gate and advances the index
    `CWF_ASSERT_NEXT(a_dest_done, state_reg == cwf_pkg::ST_DEST, state_reg == cwf_pkg::ST_IDLE && gate_cnt_reg == $past(gate_cnt_reg) + 1'b1)
    // reports only follow an operand read
    `CWF_ASSERT_IMP(a_push_after_read, push_n != 2'd0, $past(state_reg) == cwf_pkg::ST_IDLE || $past(state_reg) == cwf_pkg::ST_READ || $past(state_reg) == cwf_pkg::ST_CHECK)

endmodule

### design/cwf_seen_mem.sv
// dual-port one-bit-wide wire bitmap with registered read data
`timescale 1ns / 1ps

module cwf_seen_mem #(
    parameter int ADDR_BITS = cwf_pkg::WIRE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 a_en,
    input  logic                 a_we,
    input  logic [ADDR_BITS-1:0] a_addr,
    input  logic                 a_wdata,
    output logic                 a_rdata,
    input  logic                 b_en,
    input  logic                 b_we,
    input  logic [ADDR_BITS-1:0] b_addr,
    input  logic                 b_wdata,
    output logic                 b_rdata
);

    logic mem [2**ADDR_BITS];

    // read data holds until the next read on its port
    always_ff @(posedge clk)
    begin
        if (a_en && a_we)
        begin
            mem[a_addr] <= a_wdata;
        end
        if (b_en && b_we)
        begin
            mem[b_addr] <= b_wdata;
        end
        if (a_en && !a_we)
        begin
            a_rdata <= mem[a_addr];
        end
        if (b_en && !b_we)
        begin
            b_rdata <= mem[b_addr];
        end
    end

endmodule
